@@ hw/rtl/amt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_pkg
// Shared constants of the box transform unit: default component and fraction
// widths of the packed signed fixed-point 3-vectors.
// ----------------------------------------------------------------------------
package amt_pkg;

  localparam int AMT_COMPONENT_BITS = 16;
  localparam int AMT_FRACTION_BITS  = 8;

endpackage

@@ hw/rtl/amt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_in_if / amt_out_if
// Valid/ready channels of the box transform unit: object items in, world box
// items out. Vectors pack x, y, z signed components, x in the low bits.
// ----------------------------------------------------------------------------
interface amt_in_if
  import amt_pkg::*;
#(
  parameter int COMPONENT_BITS = AMT_COMPONENT_BITS
) ();
  localparam int PackBits = 3 * COMPONENT_BITS;

  logic                valid;
  logic                ready;
  logic [PackBits-1:0] mesh_min;
  logic [PackBits-1:0] mesh_max;
  logic [PackBits-1:0] basis_right;
  logic [PackBits-1:0] basis_up;
  logic [PackBits-1:0] basis_forward;
  logic [PackBits-1:0] translation;
  logic [PackBits-1:0] existing_min;
  logic [PackBits-1:0] existing_max;

  modport source (
    output valid, mesh_min, mesh_max, basis_right, basis_up, basis_forward,
           translation, existing_min, existing_max,
    input  ready
  );
  modport sink (
    input  valid, mesh_min, mesh_max, basis_right, basis_up, basis_forward,
           translation, existing_min, existing_max,
    output ready
  );
endinterface

interface amt_out_if
  import amt_pkg::*;
#(
  parameter int COMPONENT_BITS = AMT_COMPONENT_BITS
) ();
  localparam int PackBits = 3 * COMPONENT_BITS;

  logic                valid;
  logic                ready;
  logic [PackBits-1:0] world_min;
  logic [PackBits-1:0] world_max;
  logic                was_computed;
  logic                saturated;

  modport source (
    output valid, world_min, world_max, was_computed, saturated,
    input  ready
  );
  modport sink (
    input  valid, world_min, world_max, was_computed, saturated,
    output ready
  );
endinterface

@@ hw/rtl/aabb_matrix_transform_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_matrix_transform_unit
// World-space bounding box of one object by Arvo's method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one object per item: local box, three basis columns, the
//   translation and the box the object already holds. out_o returns one
//   world box per item, in order. An all-zero existing box is recomputed
//   (centre through the matrix, half-extent through |M|, rounded half up,
//   saturated); any other existing box is passed through unchanged.
//   Pipeline: four register stages (operand prep, products, sums,
//   round/clamp).
//   Throughput: one item per cycle while out_o is not stalled, set by the
//   nine signed and nine unsigned multipliers of the product stage in parallel.
//   Reset clears every stage valid bit; no item is in flight afterwards.
//   When the receiver stalls, the held result stays on out_o and earlier
//   stages keep filling bubbles; in_i.ready drops only with all four stages
//   occupied and the output not taken.
// ----------------------------------------------------------------------------
module aabb_matrix_transform_unit
  import amt_pkg::*;
#(
  parameter int COMPONENT_BITS = AMT_COMPONENT_BITS,
  parameter int FRACTION_BITS  = AMT_FRACTION_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amt_in_if.sink    in_i,
  amt_out_if.source out_o
);

  localparam int CB  = COMPONENT_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int PW  = 3 * CB;
  localparam int SW  = CB + 1;
  localparam int PRW = 2 * CB + 1;
  localparam int AW  = 2 * CB + FB + 4;

  localparam logic signed [AW-1:0] CompMax  = (AW'(1) <<< (CB - 1)) - AW'(1);
  localparam logic signed [AW-1:0] CompMin  = -CompMax - AW'(1);
  localparam logic signed [AW-1:0] RoundAdd = AW'(1) <<< FB;

  // handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic adv1, adv2, adv3, adv_o;

  assign adv_o      = !out_valid_q || out_o.ready;
  assign adv3       = !s3_valid_q || adv_o;
  assign adv2       = !s2_valid_q || adv3;
  assign adv1       = !s1_valid_q || adv2;
  assign in_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1)  s1_valid_q  <= in_i.valid;
      if (adv2)  s2_valid_q  <= s1_valid_q;
      if (adv3)  s3_valid_q  <= s2_valid_q;
      if (adv_o) out_valid_q <= s3_valid_q;
    end
  end

  // stage 1: operand preparation
  logic signed [SW-1:0] c2_d [3];
  logic        [SW-1:0] e2_d [3];
  logic signed [CB-1:0] m_d  [3][3];
  logic        [CB-1:0] am_d [3][3];
  logic signed [CB-1:0] t_d  [3];
  logic                 comp_d;

  logic signed [SW-1:0] c2_q [3];
  logic        [SW-1:0] e2_q [3];
  logic signed [CB-1:0] m_q  [3][3];
  logic        [CB-1:0] am_q [3][3];
  logic signed [CB-1:0] t_q  [3];
  logic                 s1_comp_q;
  logic [PW-1:0]        s1_exmin_q, s1_exmax_q;

  always_comb begin
    logic signed [CB-1:0] a, b;
    logic signed [SW-1:0] diff;
    for (int k = 0; k < 3; k++) begin
      a       = $signed(in_i.mesh_min[k*CB +: CB]);
      b       = $signed(in_i.mesh_max[k*CB +: CB]);
      c2_d[k] = SW'(a) + SW'(b);
      diff    = SW'(b) - SW'(a);
      e2_d[k] = diff[SW-1] ? $unsigned(-diff) : $unsigned(diff);
      t_d[k]  = $signed(in_i.translation[k*CB +: CB]);
    end
    for (int r = 0; r < 3; r++) begin
      m_d[r][0] = $signed(in_i.basis_right[r*CB +: CB]);
      m_d[r][1] = $signed(in_i.basis_up[r*CB +: CB]);
      m_d[r][2] = $signed(in_i.basis_forward[r*CB +: CB]);
      for (int k = 0; k < 3; k++) begin
        am_d[r][k] = m_d[r][k][CB-1] ? $unsigned(-m_d[r][k]) : $unsigned(m_d[r][k]);
      end
    end
    comp_d = (in_i.existing_min == '0) && (in_i.existing_max == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      c2_q       <= c2_d;
      e2_q       <= e2_d;
      m_q        <= m_d;
      am_q       <= am_d;
      t_q        <= t_d;
      s1_comp_q  <= comp_d;
      s1_exmin_q <= in_i.existing_min;
      s1_exmax_q <= in_i.existing_max;
    end
  end

  // stage 2: products
  logic signed [PRW-1:0] pc_d [3][3];
  logic        [PRW-1:0] pe_d [3][3];
  logic signed [PRW-1:0] pc_q [3][3];
  logic        [PRW-1:0] pe_q [3][3];
  logic signed [CB-1:0]  s2_t_q [3];
  logic                  s2_comp_q;
  logic [PW-1:0]         s2_exmin_q, s2_exmax_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pc_d[r][k] = PRW'(m_q[r][k]) * PRW'(c2_q[k]);
        pe_d[r][k] = PRW'(am_q[r][k]) * PRW'(e2_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pc_q       <= pc_d;
      pe_q       <= pe_d;
      s2_t_q     <= t_q;
      s2_comp_q  <= s1_comp_q;
      s2_exmin_q <= s1_exmin_q;
      s2_exmax_q <= s1_exmax_q;
    end
  end

  // stage 3: centre and extent sums
  logic signed [AW-1:0] ctr_d [3];
  logic        [AW-1:0] ext_d [3];
  logic signed [AW-1:0] ctr_q [3];
  logic        [AW-1:0] ext_q [3];
  logic                 s3_comp_q;
  logic [PW-1:0]        s3_exmin_q, s3_exmax_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ctr_d[r] = (AW'(s2_t_q[r]) <<< (FB + 1)) + AW'(pc_q[r][0]) + AW'(pc_q[r][1])
               + AW'(pc_q[r][2]);
      ext_d[r] = AW'(pe_q[r][0]) + AW'(pe_q[r][1]) + AW'(pe_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      ctr_q      <= ctr_d;
      ext_q      <= ext_d;
      s3_comp_q  <= s2_comp_q;
      s3_exmin_q <= s2_exmin_q;
      s3_exmax_q <= s2_exmax_q;
    end
  end

  // stage 4: round half up, clamp, select
  logic [PW-1:0] wmin_d, wmax_d;
  logic          sat_d;
  logic [PW-1:0] wmin_q, wmax_q;
  logic          comp_q, sat_q;

  always_comb begin
    logic signed [AW-1:0] lo, hi, qlo, qhi;
    logic                 sat;
    sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      lo  = ctr_q[r] - $signed(ext_q[r]) + RoundAdd;
      hi  = ctr_q[r] + $signed(ext_q[r]) + RoundAdd;
      qlo = lo >>> (FB + 1);
      qhi = hi >>> (FB + 1);
      if (qlo > CompMax) begin
        qlo = CompMax;
        sat = 1'b1;
      end else if (qlo < CompMin) begin
        qlo = CompMin;
        sat = 1'b1;
      end
      if (qhi > CompMax) begin
        qhi = CompMax;
        sat = 1'b1;
      end else if (qhi < CompMin) begin
        qhi = CompMin;
        sat = 1'b1;
      end
      wmin_d[r*CB +: CB] = qlo[CB-1:0];
      wmax_d[r*CB +: CB] = qhi[CB-1:0];
    end
    if (!s3_comp_q) begin
      wmin_d = s3_exmin_q;
      wmax_d = s3_exmax_q;
      sat    = 1'b0;
    end
    sat_d = sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      wmin_q <= wmin_d;
      wmax_q <= wmax_d;
      comp_q <= s3_comp_q;
      sat_q  <= sat_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.world_min    = wmin_q;
  assign out_o.world_max    = wmax_q;
  assign out_o.was_computed = comp_q;
  assign out_o.saturated    = sat_q;

  // checks
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline stage");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted item lost at stage one");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && adv_o && !s3_comp_q) |=>
      (out_o.world_min == $past(s3_exmin_q) && out_o.world_max == $past(s3_exmax_q)
       && !out_o.saturated))
    else $error("existing box not passed through");

  a_sat_only_computed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.was_computed) |-> !out_o.saturated)
    else $error("saturation flagged on a passed-through box");

endmodule
